### src/pms_pkg.sv
`default_nettype none
package pms_pkg;

  // Sequencer step numbers inside one tick computation.
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CNT_AXIS0  = 1;
  localparam int unsigned CNT_AXISL  = 3;
  localparam int unsigned CNT_DIVL   = 15;
  localparam int unsigned CNT_BLENDX = 16;
  localparam int unsigned CNT_BLENDY = 17;
  localparam int unsigned CNT_LAST   = 18;

  // Input kinds carried on tuser.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_SPAWN = 1'b1;

  // Register indexes.
  localparam logic [1:0] REG_START_X = 2'd0;
  localparam logic [1:0] REG_START_Y = 2'd1;
  localparam logic [1:0] REG_END_X   = 2'd2;
  localparam logic [1:0] REG_END_Y   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             run;
    logic [CNT_W-1:0] cnt;
    logic             fin;
  } pms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alive;
    logic out_busy;
  } pms_sts_t;

endpackage
`default_nettype wire

### src/particle_motion_step_top.sv
// Spawns and dead ticks go straight to the output slot; a live tick first runs the sequencer.
// One item is taken at a time: a new input is accepted only when idle and the output slot is free or draining.
// A live tick runs the 16-step restoring divider for the age fraction,
// followed by the scale blend and elapsed update.
// Reset is asynchronous and active low; it returns the particle and registers to defaults.
`default_nettype none
module particle_motion_step_top
  import pms_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
)(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in, life_in,
  // drag_in, delta_time
  input  wire logic [255:0] s_axis_tdata,
  // action
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, scale_x, scale_y, elapsed
  output logic [255:0]      m_axis_tdata,
  // alive, newly_spawned
  output logic [1:0]        m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] start_x_q, start_y_q, end_x_q, end_y_q;
  pms_cmd_t    cmd;
  pms_sts_t    sts;

  // Scale registers.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= 16'd256;
      start_y_q <= 16'd256;
      end_x_q   <= 16'd256;
      end_y_q   <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_START_X: start_x_q <= pwdata[15:0];
        REG_START_Y: start_y_q <= pwdata[15:0];
        REG_END_X:   end_x_q   <= pwdata[15:0];
        REG_END_Y:   end_y_q   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START_X: prdata = {16'd0, start_x_q};
      REG_START_Y: prdata = {16'd0, start_y_q};
      REG_END_X:   prdata = {16'd0, end_x_q};
      REG_END_Y:   prdata = {16'd0, end_y_q};
      default:     prdata = '0;
    endcase
  end

  pms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pms_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .start_x_i   (start_x_q),
    .start_y_i   (start_y_q),
    .end_x_i     (end_x_q),
    .end_y_i     (end_y_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
`default_nettype wire

### src/pms_ctrl.sv
`default_nettype none
module pms_ctrl
  import pms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_action_i,
  input  wire logic     out_ready_i,
  output logic          in_ready_o,
  output pms_cmd_t      cmd_o,
  input  wire pms_sts_t sts_i
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acc;

  // An item is taken when idle and the output slot is free or draining.
  assign in_ready_o = (state_q == ST_IDLE) && (!sts_i.out_busy || out_ready_i);
  assign acc        = in_ready_o && in_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (acc) begin
          if (in_action_i == ACT_TICK && sts_i.alive) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CNT_LAST)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o.accept = acc;
    cmd_o.run    = (state_q == ST_RUN);
    cmd_o.cnt    = cnt_q;
    cmd_o.fin    = (state_q == ST_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### src/pms_dp.sv
`default_nettype none
module pms_dp
  import pms_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
)(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pms_cmd_t           cmd_i,
  output pms_sts_t                sts_o,
  input  wire logic               action_i,
  input  wire logic [255:0]       in_data_i,
  input  wire logic [15:0]        start_x_i,
  input  wire logic [15:0]        start_y_i,
  input  wire logic [15:0]        end_x_i,
  input  wire logic [15:0]        end_y_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [255:0]            out_data_o,
  output logic [1:0]              out_user_o
);

  localparam logic [24:0] ONE_Q24 = 25'd1 << 24;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [15:0]        scl_x_q, scl_y_q;
  logic [31:0]        life_q, elap_q;
  logic [15:0]        drag_q, dt_q;
  logic               flag_q;

  logic [24:0]        factor_q;
  logic signed [48:0] mstep_q;
  logic signed [57:0] mvel_q;
  logic [1:0]         kidx_q;
  logic [32:0]        rem_q;
  logic [15:0]        quo_q;
  logic [32:0]        blend_q;

  logic               out_valid_q;
  logic [255:0]       out_data_q;
  logic [1:0]         out_user_q;

  logic               alive;
  logic [31:0]        dprod;
  logic [1:0]         kcur;
  logic [32:0]        rin, rsh;
  logic [16:0]        ainv;
  logic [32:0]        bsum;
  logic [15:0]        bs, be;
  logic signed [32:0] step;
  logic signed [33:0] psum;
  logic signed [31:0] psat;
  logic [39:0]        addw;
  logic [32:0]        esum;

  assign alive           = (elap_q < life_q);
  assign sts_o.alive     = alive;
  assign sts_o.out_busy  = out_valid_q;

  // Drag product, divider remainder, blend terms, axis position sum and elapsed sum.
  always_comb begin
    dprod = 32'(drag_q) * 32'(dt_q);
    kcur  = 2'(cmd_i.cnt - CNT_W'(CNT_AXIS0));
    rin   = (cmd_i.cnt == '0) ? {1'b0, elap_q} : rem_q;
    rsh   = {rin[31:0], 1'b0};
    ainv  = 17'h10000 - {1'b0, quo_q};
    bs    = (cmd_i.cnt == CNT_W'(CNT_BLENDX)) ? start_x_i : start_y_i;
    be    = (cmd_i.cnt == CNT_W'(CNT_BLENDX)) ? end_x_i : end_y_i;
    bsum  = 33'(bs) * 33'(ainv) + 33'(be) * 33'(quo_q);
    step  = 33'(mstep_q >>> 16);
    psum  = 34'(pos_q[kidx_q]) + 34'(step);
    if (psum > 34'sh7FFFFFFF) begin
      psat = 32'sh7FFFFFFF;
    end else if (psum < -34'sh80000000) begin
      psat = -32'sh80000000;
    end else begin
      psat = psum[31:0];
    end
    addw = ({24'd0, dt_q} << FRAC_BITS) >> 16;
    esum = {1'b0, elap_q} + 33'(addw);
  end

  // Particle state and tick sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
      end
      scl_x_q <= 16'd256;
      scl_y_q <= 16'd256;
      life_q  <= '0;
      elap_q  <= 32'(64'd1 << FRAC_BITS);
      drag_q  <= '0;
      flag_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && action_i == ACT_SPAWN) begin
        pos_q[0] <= in_data_i[31:0];
        pos_q[1] <= in_data_i[63:32];
        pos_q[2] <= in_data_i[95:64];
        vel_q[0] <= in_data_i[127:96];
        vel_q[1] <= in_data_i[159:128];
        vel_q[2] <= in_data_i[191:160];
        life_q   <= in_data_i[223:192];
        drag_q   <= in_data_i[239:224];
        scl_x_q  <= start_x_i;
        scl_y_q  <= start_y_i;
        elap_q   <= '0;
        flag_q   <= 1'b1;
      end
      if (cmd_i.run) begin
        // Axis results are written from the registered axis products.
        if (cmd_i.cnt > CNT_W'(CNT_AXIS0) && cmd_i.cnt <= CNT_W'(CNT_AXISL + 1)) begin
          pos_q[kidx_q] <= psat;
          vel_q[kidx_q] <= mvel_q[55:24];
        end
        if (cmd_i.cnt == CNT_W'(CNT_BLENDY)) begin
          scl_x_q <= blend_q[31:16];
        end
        if (cmd_i.cnt == CNT_W'(CNT_LAST)) begin
          scl_y_q <= blend_q[31:16];
          elap_q  <= esum[32] ? 32'hFFFFFFFF : esum[31:0];
        end
      end
      if (cmd_i.fin) begin
        flag_q <= 1'b0;
      end
    end
  end

  // Work registers of the tick: products, divider, blend.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dt_q <= in_data_i[255:240];
    end
    if (cmd_i.run) begin
      if (cmd_i.cnt == '0) begin
        factor_q <= (dprod >= 32'(ONE_Q24)) ? '0 : 25'(32'(ONE_Q24) - dprod);
      end
      if (cmd_i.cnt >= CNT_W'(CNT_AXIS0) && cmd_i.cnt <= CNT_W'(CNT_AXISL)) begin
        mstep_q <= vel_q[kcur] * $signed({1'b0, dt_q});
        mvel_q  <= vel_q[kcur] * $signed({1'b0, factor_q});
        kidx_q  <= kcur;
      end
      if (cmd_i.cnt <= CNT_W'(CNT_DIVL)) begin
        if (rsh >= {1'b0, life_q}) begin
          rem_q <= rsh - {1'b0, life_q};
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= rsh;
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
      if (cmd_i.cnt == CNT_W'(CNT_BLENDX) || cmd_i.cnt == CNT_W'(CNT_BLENDY)) begin
        blend_q <= bsum;
      end
    end
  end

  // Output slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_data_q <= {elap_q, scl_y_q, scl_x_q, vel_q[2], vel_q[1], vel_q[0],
                     pos_q[2], pos_q[1], pos_q[0]};
      out_user_q <= {flag_q, alive};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule
`default_nettype wire
